// ===== design/hsv_range_color_vote_assert.svh =====
// assertion macros for the hsv range color vote block
// plain text header, no dependencies
`ifndef HSV_RANGE_COLOR_VOTE_ASSERT_SVH
`define HSV_RANGE_COLOR_VOTE_ASSERT_SVH

// same-cycle implication
`define HRCV_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("hsv_range_color_vote: implication check failed");

// next-cycle implication
`define HRCV_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("hsv_range_color_vote: next-cycle check failed");

`endif

// ===== design/hrcv_pkg.sv =====
// types, constants and color box test for the hsv range color vote block
// no dependencies
`default_nettype none

package hrcv_pkg;

	localparam int NUM_CLASS = 5;
	localparam logic [23:0] OUT_COUNT_MAX = 24'hFFFFFF;

	typedef enum logic [2:0] {
		CLS_NONE = 3'd0,
		CLS_X2   = 3'd1,
		CLS_X4   = 3'd2,
		CLS_X10  = 3'd3,
		CLS_X20  = 3'd4,
		CLS_X40  = 3'd5
	} mag_class_t;

	typedef enum logic [1:0] {
		REG_LEFT   = 2'd0,
		REG_TOP    = 2'd1,
		REG_WIDTH  = 2'd2,
		REG_HEIGHT = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]  pixel_blue;
		logic [7:0]  pixel_green;
		logic [7:0]  pixel_red;
		logic [11:0] pixel_column;
		logic [11:0] pixel_row;
		logic        frame_end;
	} pixel_t;

	typedef struct packed {
		logic [2:0]  magnification_class;
		logic [23:0] winning_count;
	} result_t;

	typedef struct packed {
		logic [8:0] h_lo;
		logic [8:0] h_hi;
		logic [7:0] s_lo;
		logic [7:0] s_hi;
		logic [7:0] v_lo;
		logic [7:0] v_hi;
	} box_t;

	// counter index order: x2, x4, x10, x20, x40
	localparam box_t BOXES [NUM_CLASS] = '{
		'{h_lo: 9'd274, h_hi: 9'd320, s_lo: 8'd94,  s_hi: 8'd215, v_lo: 8'd52,  v_hi: 8'd219},
		'{h_lo: 9'd327, h_hi: 9'd360, s_lo: 8'd104, s_hi: 8'd255, v_lo: 8'd100, v_hi: 8'd255},
		'{h_lo: 9'd32,  h_hi: 9'd77,  s_lo: 8'd70,  s_hi: 8'd255, v_lo: 8'd91,  v_hi: 8'd255},
		'{h_lo: 9'd93,  h_hi: 9'd198, s_lo: 8'd73,  s_hi: 8'd244, v_lo: 8'd65,  v_hi: 8'd146},
		'{h_lo: 9'd173, h_hi: 9'd254, s_lo: 8'd153, s_hi: 8'd255, v_lo: 8'd106, v_hi: 8'd197}
	};

	localparam mag_class_t CLASS_OF_IDX [NUM_CLASS] = '{
		CLS_X2, CLS_X4, CLS_X10, CLS_X20, CLS_X40
	};

	// exact rational box test: hue = hn/d, sat = d/mx, value = mx/255
	function automatic logic box_match(input box_t bx, input logic [16:0] hn,
		input logic [7:0] d, input logic [7:0] mx);
		logic        v_ok;
		logic        s_ok;
		logic        h_ok;
		logic [15:0] slo_mx;
		logic [15:0] shi_mx;
		logic [15:0] d255;
		logic [16:0] hlo_d;
		logic [16:0] hhi_d;
		begin
			slo_mx = 16'(bx.s_lo) * 16'(mx);
			shi_mx = 16'(bx.s_hi) * 16'(mx);
			d255   = 16'(d) * 16'd255;
			hlo_d  = 17'(bx.h_lo) * 17'(d);
			hhi_d  = 17'(bx.h_hi) * 17'(d);
			v_ok = (mx >= bx.v_lo) && (mx <= bx.v_hi);
			s_ok = (mx == 8'd0) ? (bx.s_lo == 8'd0) : ((slo_mx <= d255) && (d255 <= shi_mx));
			h_ok = (d == 8'd0) ? (bx.h_lo == 9'd0) : ((hlo_d <= hn) && (hn <= hhi_d));
			return v_ok && s_ok && h_ok;
		end
	endfunction

endpackage

`default_nettype wire

// ===== design/hsv_range_color_vote.sv =====
// path: a frame_end request passes the input, match-flag, vote-request and result registers
// throughput: one pixel per cycle; input stalls only when a second frame
//   result would overtake one still waiting at the output
// reset: asynchronous, clears counters, region registers and all valid flags
// holds the region compare, hsv box tests, class counters and the vote
// depends on hrcv_pkg and hsv_range_color_vote_assert.svh
`default_nettype none
`include "hsv_range_color_vote_assert.svh"

module hsv_range_color_vote #(
	parameter int COORD_BITS = 12,
	parameter int COUNT_BITS = 24
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            pixel_valid,
	output logic                 pixel_stall,
	input  wire hrcv_pkg::pixel_t pixel,
	output logic                 result_valid,
	input  wire logic            result_stall,
	output hrcv_pkg::result_t    result,
	input  wire logic            cfg_write,
	input  wire logic [1:0]      cfg_index,
	input  wire logic [11:0]     cfg_data
);

	localparam int NC = hrcv_pkg::NUM_CLASS;

	logic [COORD_BITS-1:0] left_q, top_q, width_q, height_q;
	logic [COORD_BITS-1:0] cfg_val;

	logic                  valid_s1;
	hrcv_pkg::pixel_t      pix_s1;
	logic                  valid_s2, last_s2;
	logic [NC-1:0]         match_s2;
	logic                  valid_s3, last_s3;
	logic [COUNT_BITS-1:0] count_q [NC];

	logic                  freeze;
	logic                  vote_now;

	// configuration
	assign cfg_val = COORD_BITS'(16'(cfg_data));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			top_q    <= '0;
			width_q  <= '0;
			height_q <= '0;
		end else if (cfg_write) begin
			unique case (hrcv_pkg::cfg_reg_t'(cfg_index))
				hrcv_pkg::REG_LEFT:   left_q   <= cfg_val;
				hrcv_pkg::REG_TOP:    top_q    <= cfg_val;
				hrcv_pkg::REG_WIDTH:  width_q  <= cfg_val;
				hrcv_pkg::REG_HEIGHT: height_q <= cfg_val;
				default: ;
			endcase
		end
	end

	// flow control
	assign vote_now    = valid_s3 && last_s3;
	assign freeze      = vote_now && result_valid && result_stall;
	assign pixel_stall = freeze;

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!freeze) begin
			valid_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!freeze && pixel_valid) begin
			pix_s1 <= pixel;
		end
	end

	// region and hsv tests
	logic [COORD_BITS-1:0] col, row;
	logic [COORD_BITS:0]   col_end, row_end;
	logic                  in_rect;
	logic [7:0]            r, g, b, mx, mn, d;
	logic signed [18:0]    sr, sg, sb, sd, hn_raw, hn_adj;
	logic [16:0]           hn;
	logic [NC-1:0]         match;

	always_comb begin
		col     = COORD_BITS'(16'(pix_s1.pixel_column));
		row     = COORD_BITS'(16'(pix_s1.pixel_row));
		col_end = {1'b0, left_q} + {1'b0, width_q};
		row_end = {1'b0, top_q} + {1'b0, height_q};
		in_rect = (col >= left_q) && ({1'b0, col} < col_end) &&
			(row >= top_q) && ({1'b0, row} < row_end);

		r  = pix_s1.pixel_red;
		g  = pix_s1.pixel_green;
		b  = pix_s1.pixel_blue;
		mx = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		mn = r;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d  = mx - mn;

		sr = $signed({11'b0, r});
		sg = $signed({11'b0, g});
		sb = $signed({11'b0, b});
		sd = $signed({11'b0, d});
		if (d == 8'd0)
			hn_raw = '0;
		else if (mx == r)
			hn_raw = 19'sd60 * (sg - sb);
		else if (mx == g)
			hn_raw = 19'sd60 * (sb - sr) + 19'sd120 * sd;
		else
			hn_raw = 19'sd60 * (sr - sg) + 19'sd240 * sd;
		hn_adj = (hn_raw < 0) ? hn_raw + 19'sd360 * sd : hn_raw;
		hn     = hn_adj[16:0];

		for (int i = 0; i < NC; i++) begin
			match[i] = valid_s1 && in_rect && hrcv_pkg::box_match(hrcv_pkg::BOXES[i], hn, d, mx);
		end
	end

	// stage 2: match flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
			match_s2 <= '0;
		end else if (!freeze) begin
			valid_s2 <= valid_s1;
			last_s2  <= valid_s1 && pix_s1.frame_end;
			match_s2 <= match;
		end
	end

	// class counters, restarted from the next frame's first match flags as the vote is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NC; i++) count_q[i] <= '0;
		end else if (!freeze) begin
			for (int i = 0; i < NC; i++) begin
				if (vote_now)
					count_q[i] <= COUNT_BITS'(match_s2[i]);
				else if (match_s2[i] && !(&count_q[i]))
					count_q[i] <= count_q[i] + COUNT_BITS'(1);
			end
		end
	end

	// stage 3: vote request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			last_s3  <= 1'b0;
		end else if (!freeze) begin
			valid_s3 <= valid_s2;
			last_s3  <= last_s2;
		end
	end

	// vote tree, earlier in x10, x2, x20, x4, x40 wins ties
	logic [2:0]            idx_a, idx_b, idx_ab, idx_win;
	logic [COUNT_BITS-1:0] best;
	logic [31:0]           best32;
	hrcv_pkg::result_t     vote;

	always_comb begin
		idx_a   = (count_q[0] > count_q[2]) ? 3'd0 : 3'd2;
		idx_b   = (count_q[1] > count_q[3]) ? 3'd1 : 3'd3;
		idx_ab  = (count_q[idx_b] > count_q[idx_a]) ? idx_b : idx_a;
		idx_win = (count_q[4] > count_q[idx_ab]) ? 3'd4 : idx_ab;
		best    = count_q[idx_win];
		best32  = 32'(best);
		vote.magnification_class = (best == '0) ? hrcv_pkg::CLS_NONE :
			hrcv_pkg::CLASS_OF_IDX[idx_win];
		vote.winning_count = (best32 > 32'(hrcv_pkg::OUT_COUNT_MAX)) ?
			hrcv_pkg::OUT_COUNT_MAX : best32[23:0];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (!freeze && vote_now) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!freeze && vote_now) begin
			result <= vote;
		end
	end

	`HRCV_ASSERT_IMPLY(a_stall_cause, clk, arst_n, pixel_stall,
		vote_now && result_valid && result_stall)
	`HRCV_ASSERT_NEXT(a_vote_lands, clk, arst_n, vote_now && !freeze, result_valid)
	`HRCV_ASSERT_IMPLY(a_match_needs_valid, clk, arst_n, !valid_s2, match_s2 == '0)
	`HRCV_ASSERT_IMPLY(a_none_is_zero, clk, arst_n,
		result_valid && (result.magnification_class == hrcv_pkg::CLS_NONE),
		result.winning_count == '0)

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// self-checking bench for hsv_range_color_vote: directed table, back-to-back frame ends, then random frames
// predicts the per-frame color vote from pixels as they are accepted
// depends on hrcv_pkg and the design sources
module tb_top;

	localparam int RANDOM_ITEMS = 800;
	localparam int MAX_GAP = 17;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 6;
	localparam int DIR_ROWS = 22;
	localparam int PRESSURE_ITEMS = 24;

	localparam logic [1:0] RG_RESET = 2'd0;
	localparam logic [1:0] RG_FULL = 2'd1;
	localparam logic [1:0] RG_CORNER = 2'd2;
	localparam logic [1:0] RG_DOT = 2'd3;

	// slot order x2, x4, x10, x20, x40
	localparam int H_LO [hrcv_pkg::NUM_CLASS] = '{274, 327, 32, 93, 173};
	localparam int H_HI [hrcv_pkg::NUM_CLASS] = '{320, 360, 77, 198, 254};
	localparam int S_LO [hrcv_pkg::NUM_CLASS] = '{94, 104, 70, 73, 153};
	localparam int S_HI [hrcv_pkg::NUM_CLASS] = '{215, 255, 255, 244, 255};
	localparam int V_LO [hrcv_pkg::NUM_CLASS] = '{52, 100, 91, 65, 106};
	localparam int V_HI [hrcv_pkg::NUM_CLASS] = '{219, 255, 255, 146, 197};
	localparam int TIE_ORDER [hrcv_pkg::NUM_CLASS] = '{2, 0, 3, 1, 4};
	localparam hrcv_pkg::mag_class_t SLOT_CLASS [hrcv_pkg::NUM_CLASS] = '{
		hrcv_pkg::CLS_X2, hrcv_pkg::CLS_X4, hrcv_pkg::CLS_X10,
		hrcv_pkg::CLS_X20, hrcv_pkg::CLS_X40};
	localparam int TALLY_MAX = 24'hFFFFFF;

	// typical colors per slot, blue/green/red
	localparam logic [7:0] PROTO_B [hrcv_pkg::NUM_CLASS] = '{8'd200, 8'd100, 8'd0, 8'd100, 8'd180};
	localparam logic [7:0] PROTO_G [hrcv_pkg::NUM_CLASS] = '{8'd100, 8'd0, 8'd255, 8'd140, 8'd50};
	localparam logic [7:0] PROTO_R [hrcv_pkg::NUM_CLASS] = '{8'd200, 8'd255, 8'd255, 8'd20, 8'd0};

	typedef struct packed {
		logic [11:0] left;
		logic [11:0] top;
		logic [11:0] width;
		logic [11:0] height;
	} region_t;

	typedef struct packed {
		hrcv_pkg::pixel_t  px;
		logic [1:0]        rgn;
		logic              typed;
		hrcv_pkg::result_t fixed;
	} dir_row_t;

	localparam region_t REGION_SET [4] = '{
		'{12'd0, 12'd0, 12'd0, 12'd0},
		'{12'd0, 12'd0, 12'd4095, 12'd4095},
		'{12'd4095, 12'd4095, 12'd4095, 12'd4095},
		'{12'd10, 12'd20, 12'd1, 12'd1}
	};

	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		// registers at reset select nothing
		'{'{8'd0, 8'd0, 8'd255, 12'd0, 12'd0, 1'b1}, RG_RESET, 1'b1,
			'{hrcv_pkg::CLS_NONE, 24'd0}},
		// black, and yellow just past the right and bottom edges
		'{'{8'd0, 8'd0, 8'd0, 12'd0, 12'd0, 1'b0}, RG_FULL, 1'b0, '0},
		'{'{8'd0, 8'd255, 8'd255, 12'd4095, 12'd10, 1'b0}, RG_FULL, 1'b0, '0},
		'{'{8'd0, 8'd255, 8'd255, 12'd10, 12'd4095, 1'b0}, RG_FULL, 1'b0, '0},
		'{'{8'd255, 8'd255, 8'd255, 12'd4094, 12'd0, 1'b0}, RG_FULL, 1'b0, '0},
		'{'{8'd128, 8'd128, 8'd128, 12'd5, 12'd5, 1'b1}, RG_FULL, 1'b1,
			'{hrcv_pkg::CLS_NONE, 24'd0}},
		// x2 and x10 tie
		'{'{8'd200, 8'd100, 8'd200, 12'd4094, 12'd4094, 1'b0}, RG_FULL, 1'b0, '0},
		'{'{8'd0, 8'd255, 8'd255, 12'd0, 12'd0, 1'b1}, RG_FULL, 1'b1,
			'{hrcv_pkg::CLS_X10, 24'd1}},
		// x4, x20, x40 at two each, one pixel in both x20 and x40
		'{'{8'd100, 8'd0, 8'd255, 12'd100, 12'd7, 1'b0}, RG_FULL, 1'b0, '0},
		'{'{8'd100, 8'd0, 8'd255, 12'd101, 12'd7, 1'b0}, RG_FULL, 1'b0, '0},
		'{'{8'd100, 8'd140, 8'd20, 12'd102, 12'd7, 1'b0}, RG_FULL, 1'b0, '0},
		'{'{8'd140, 8'd130, 8'd30, 12'd103, 12'd7, 1'b0}, RG_FULL, 1'b0, '0},
		'{'{8'd180, 8'd50, 8'd0, 12'd104, 12'd7, 1'b1}, RG_FULL, 1'b0, '0},
		// value right on and just under the x10 floor
		'{'{8'd0, 8'd91, 8'd91, 12'd2048, 12'd2048, 1'b0}, RG_FULL, 1'b0, '0},
		'{'{8'd0, 8'd90, 8'd90, 12'd2047, 12'd2047, 1'b1}, RG_FULL, 1'b0, '0},
		'{'{8'd255, 8'd0, 8'd0, 12'd1, 12'd1, 1'b0}, RG_FULL, 1'b0, '0},
		'{'{8'd255, 8'd255, 8'd255, 12'd2, 12'd2, 1'b1}, RG_FULL, 1'b0, '0},
		// one-pixel rectangle and its neighbors
		'{'{8'd0, 8'd255, 8'd255, 12'd10, 12'd20, 1'b0}, RG_DOT, 1'b0, '0},
		'{'{8'd0, 8'd255, 8'd255, 12'd11, 12'd20, 1'b0}, RG_DOT, 1'b0, '0},
		'{'{8'd0, 8'd255, 8'd255, 12'd10, 12'd19, 1'b1}, RG_DOT, 1'b0, '0},
		// rectangle sum past the coordinate range, no wrap
		'{'{8'd0, 8'd255, 8'd255, 12'd4095, 12'd4095, 1'b1}, RG_CORNER, 1'b0, '0},
		'{'{8'd0, 8'd255, 8'd255, 12'd4094, 12'd4095, 1'b1}, RG_CORNER, 1'b1,
			'{hrcv_pkg::CLS_NONE, 24'd0}}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic pixel_valid;
	logic pixel_stall;
	hrcv_pkg::pixel_t pixel;
	logic result_valid;
	logic result_stall;
	hrcv_pkg::result_t result;
	logic cfg_write;
	logic [1:0] cfg_index;
	logic [11:0] cfg_data;

	region_t cur_region;
	int tally [hrcv_pkg::NUM_CLASS];
	hrcv_pkg::result_t vote_expected [$];
	int mismatches = 0;

	hsv_range_color_vote dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel(pixel),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	initial begin
		#400000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic void predict_pixel(input hrcv_pkg::pixel_t px, output bit has_vote,
		output hrcv_pkg::result_t vote);
		int b, g, r, mx, mn, d, hn, best, k;
		int col, row;
		bit hit;
		hrcv_pkg::mag_class_t cls;
		b = px.pixel_blue;
		g = px.pixel_green;
		r = px.pixel_red;
		col = px.pixel_column;
		row = px.pixel_row;
		if (col >= cur_region.left && col < cur_region.left + cur_region.width &&
			row >= cur_region.top && row < cur_region.top + cur_region.height) begin
			mx = r;
			mn = r;
			if (g > mx) mx = g;
			if (b > mx) mx = b;
			if (g < mn) mn = g;
			if (b < mn) mn = b;
			d = mx - mn;
			if (d == 0) hn = 0;
			else if (mx == r) hn = 60 * (g - b);
			else if (mx == g) hn = 60 * (b - r) + 120 * d;
			else hn = 60 * (r - g) + 240 * d;
			if (hn < 0) hn += 360 * d;
			for (int i = 0; i < hrcv_pkg::NUM_CLASS; i++) begin
				hit = mx >= V_LO[i] && mx <= V_HI[i];
				if (mx == 0) hit = hit && S_LO[i] == 0;
				else hit = hit && S_LO[i] * mx <= 255 * d && 255 * d <= S_HI[i] * mx;
				if (d == 0) hit = hit && H_LO[i] <= 0 && H_HI[i] >= 0;
				else hit = hit && H_LO[i] * d <= hn && hn <= H_HI[i] * d;
				if (hit && tally[i] < TALLY_MAX) tally[i]++;
			end
		end
		has_vote = px.frame_end;
		vote = '0;
		if (px.frame_end) begin
			best = 0;
			cls = hrcv_pkg::CLS_NONE;
			for (int i = 0; i < hrcv_pkg::NUM_CLASS; i++) begin
				k = TIE_ORDER[i];
				if (tally[k] > best) begin
					best = tally[k];
					cls = SLOT_CLASS[k];
				end
			end
			vote.magnification_class = cls;
			vote.winning_count = best[23:0];
			for (int i = 0; i < hrcv_pkg::NUM_CLASS; i++) tally[i] = 0;
		end
	endfunction

	task automatic send_pixel(input hrcv_pkg::pixel_t px, input bit no_gap, input bit typed,
		input hrcv_pkg::result_t fixed);
		int gap;
		bit has_vote;
		hrcv_pkg::result_t vote;
		gap = no_gap ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel <= px;
		@(posedge clk);
		while (pixel_stall) @(posedge clk);
		predict_pixel(px, has_vote, vote);
		if (has_vote) vote_expected.push_back(typed ? fixed : vote);
	endtask

	task automatic wait_idle();
		while (vote_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_region(input region_t rg);
		cfg_write <= 1'b1;
		cfg_index <= hrcv_pkg::REG_LEFT;
		cfg_data <= rg.left;
		@(posedge clk);
		cfg_index <= hrcv_pkg::REG_TOP;
		cfg_data <= rg.top;
		@(posedge clk);
		cfg_index <= hrcv_pkg::REG_WIDTH;
		cfg_data <= rg.width;
		@(posedge clk);
		cfg_index <= hrcv_pkg::REG_HEIGHT;
		cfg_data <= rg.height;
		@(posedge clk);
		cfg_write <= 1'b0;
		cur_region = rg;
	endtask

	function automatic logic [7:0] clamp_byte(input int v);
		if (v < 0) return 8'd0;
		if (v > 255) return 8'd255;
		return v[7:0];
	endfunction

	function automatic logic [11:0] pick_coord(input int base, input int span);
		int c;
		if (span > 0 && $urandom_range(0, 9) < 7) begin
			c = base + $urandom_range(0, span);
			if (c > 4095) c = $urandom_range(0, 4095);
		end else begin
			c = $urandom_range(0, 4095);
		end
		return c[11:0];
	endfunction

	// request side
	initial begin
		logic [1:0] region_id;
		region_t rg;
		hrcv_pkg::pixel_t px;
		int items_sent, phase_len, frame_left, sel, k;
		bit burst, short_frames;
		pixel_valid = 1'b0;
		pixel = '0;
		cfg_write = 1'b0;
		cfg_index = hrcv_pkg::REG_LEFT;
		cfg_data = '0;
		cur_region = '0;
		for (int i = 0; i < hrcv_pkg::NUM_CLASS; i++) tally[i] = 0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		region_id = RG_RESET;
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (DIRECTED[i].rgn != region_id) begin
				pixel_valid <= 1'b0;
				wait_idle();
				region_id = DIRECTED[i].rgn;
				write_region(REGION_SET[region_id]);
			end
			send_pixel(DIRECTED[i].px, 1'b0, DIRECTED[i].typed, DIRECTED[i].fixed);
		end

		// back-to-back frame ends while the receiver holds off
		px = '{8'd0, 8'd255, 8'd255, 12'd4095, 12'd4095, 1'b1};
		for (int i = 0; i < PRESSURE_ITEMS; i++)
			send_pixel(px, 1'b1, 1'b0, '0);

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 9);
			case (sel)
				0: rg = REGION_SET[RG_RESET];
				1: rg = REGION_SET[RG_FULL];
				2: rg = REGION_SET[RG_CORNER];
				3: begin
					rg = {12'($urandom), 12'($urandom), 12'd0, 12'($urandom)};
				end
				default: begin
					rg.left = 12'($urandom_range(0, 4095));
					rg.top = 12'($urandom_range(0, 4095));
					rg.width = 12'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
						: $urandom_range(1, 48));
					rg.height = 12'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
						: $urandom_range(1, 48));
				end
			endcase
			pixel_valid <= 1'b0;
			wait_idle();
			write_region(rg);
			phase_len = $urandom_range(60, 140);
			short_frames = $urandom_range(0, 1) == 1;
			frame_left = 0;
			burst = 1'b0;
			for (int n = 0; n < phase_len; n++) begin
				if (frame_left == 0) begin
					frame_left = short_frames ? $urandom_range(1, 4) : $urandom_range(1, 60);
					burst = $urandom_range(0, 3) == 0;
				end
				if ($urandom_range(0, 1) == 0) begin
					px.pixel_blue = 8'($urandom);
					px.pixel_green = 8'($urandom);
					px.pixel_red = 8'($urandom);
				end else begin
					k = $urandom_range(0, hrcv_pkg::NUM_CLASS - 1);
					px.pixel_blue = clamp_byte(int'(PROTO_B[k]) + $urandom_range(0, 48) - 24);
					px.pixel_green = clamp_byte(int'(PROTO_G[k]) + $urandom_range(0, 48) - 24);
					px.pixel_red = clamp_byte(int'(PROTO_R[k]) + $urandom_range(0, 48) - 24);
				end
				px.pixel_column = pick_coord(rg.left, rg.width);
				px.pixel_row = pick_coord(rg.top, rg.height);
				frame_left--;
				px.frame_end = frame_left == 0 || n == phase_len - 1;
				if (px.frame_end) frame_left = 0;
				send_pixel(px, burst, 1'b0, '0);
				items_sent++;
			end
		end

		pixel_valid <= 1'b0;
		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// result side
	initial begin
		int results_seen, gap;
		bit rx_burst;
		hrcv_pkg::result_t want;
		result_stall = 1'b0;
		results_seen = 0;
		rx_burst = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (results_seen % 16 == 0) rx_burst = $urandom_range(0, 2) == 0;
			// long hold-offs so the block backs up into its input
			if (results_seen == 8 || results_seen == 30 || results_seen == 60)
				gap = HOLD_CYCLES;
			else
				gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
			if (gap > 0) begin
				result_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			result_stall <= 1'b0;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
			results_seen++;
			if (vote_expected.size() == 0) begin
				report_mismatch($sformatf("unexpected result class %0d count %0d",
					result.magnification_class, result.winning_count));
			end else begin
				want = vote_expected.pop_front();
				if (result.magnification_class !== want.magnification_class)
					report_mismatch($sformatf("class got %0d want %0d",
						result.magnification_class, want.magnification_class));
				if (result.winning_count !== want.winning_count)
					report_mismatch($sformatf("count got %0d want %0d",
						result.winning_count, want.winning_count));
			end
		end
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/hrcv_pkg.sv
design/hsv_range_color_vote.sv
test/tb_top.sv
